/* hdl/lfid_pkg.sv */
// Package for the lowest free ID allocator: transaction types, status codes, step directions and sequencer states.
package lfid_pkg;

    // Result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    // Request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [5:0] slot_index;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] granted_id;
        logic [6:0] in_use_count;
        logic [6:0] high_mark;
    } t_out_item;

    // Direction of the shared pointer step unit
    typedef enum logic {
        SCAN_UP,
        SCAN_DOWN
    } t_scan_op;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALLOC_RD,
        ST_ALLOC_CHK,
        ST_FREE_RD,
        ST_FREE_CHK,
        ST_FREE_SCAN_RD,
        ST_FREE_SCAN_CHK,
        ST_DONE
    } t_state;

endpackage

/* hdl/lowest_free_id_allocator.sv */
// Top level of the lowest free ID allocator: sequencer, pointer registers and result register.
//
//  channel  | valid       | ready        | payload
//  ---------+-------------+--------------+------------------------
//  request  | i_in_valid  | o_in_ready   | i_in_data  (t_in_item)
//  result   | o_out_valid | i_out_ready  | o_out_data (t_out_item)
//
// After reset the map is cleared one slot a cycle, with o_in_ready low until the sweep ends.
// A full allocate or an out-of-range free goes straight to the final state. A free
// reads its slot first; an allocate steps up over occupied slots and a free of an occupied
// slot walks the end mark down past empty slots, each until the walk runs off its end.
// A new transaction is taken while the previous result still waits; a stalled result
// holds the sequencer in its final state until the result register frees up.
module lowest_free_id_allocator #(
    parameter int TABLE_SIZE = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  lfid_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output lfid_pkg::t_out_item  o_out_data
);

    import lfid_pkg::*;

    localparam int AW = $clog2(TABLE_SIZE);
    localparam int PW = $clog2(TABLE_SIZE + 1);
    localparam logic [PW-1:0] FULL_PTR  = PW'(TABLE_SIZE);
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_SIZE - 1);

    t_state        r_state,      n_state;
    logic [PW-1:0] r_first_free, n_first_free;
    logic [PW-1:0] r_end_mark,   n_end_mark;
    logic [PW-1:0] r_used,       n_used;
    logic [PW-1:0] r_ptr,        n_ptr;
    logic [AW-1:0] r_slot,       n_slot;
    logic [AW-1:0] r_clr_addr,   n_clr_addr;
    logic [1:0]    r_status,     n_status;
    logic [5:0]    r_grant,      n_grant;
    logic          r_out_valid,  n_out_valid;
    t_out_item     r_out,        n_out;

    logic          in_accept;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          wr_data;
    logic [AW-1:0] rd_addr;
    logic          rd_data;
    t_scan_op      step_op;
    logic [PW-1:0] step_ptr;
    logic [PW-1:0] step_next;
    logic          step_stop;

    lfid_map_ram #(
        .DEPTH(TABLE_SIZE)
    ) u_map (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    lfid_scan_unit #(
        .TABLE_SIZE(TABLE_SIZE)
    ) u_step (
        .i_op  (step_op),
        .i_ptr (step_ptr),
        .o_next(step_next),
        .o_stop(step_stop)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Step unit input: free pointer when a request arrives, scan pointer otherwise
    always_comb begin
        step_op  = SCAN_UP;
        step_ptr = r_ptr;
        case (r_state)
            ST_IDLE: begin
                step_ptr = r_first_free;
            end
            ST_FREE_RD, ST_FREE_CHK, ST_FREE_SCAN_RD, ST_FREE_SCAN_CHK: begin
                step_op = SCAN_DOWN;
            end
            default: begin
                step_op = SCAN_UP;
            end
        endcase
    end

    // Sequencer: next state, map accesses and register updates
    always_comb begin
        n_state      = r_state;
        n_first_free = r_first_free;
        n_end_mark   = r_end_mark;
        n_used       = r_used;
        n_ptr        = r_ptr;
        n_slot       = r_slot;
        n_clr_addr   = r_clr_addr;
        n_status     = r_status;
        n_grant      = r_grant;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_out_ready;
        wr_en        = 1'b0;
        wr_addr      = r_first_free[AW-1:0];
        wr_data      = 1'b0;
        rd_addr      = r_ptr[AW-1:0];

        case (r_state)
            // Sweep zeros through the map after reset
            ST_CLEAR: begin
                wr_en      = 1'b1;
                wr_addr    = r_clr_addr;
                wr_data    = 1'b0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (in_accept) begin
                    if (i_in_data.kind == KIND_ALLOC) begin
                        if (r_first_free == FULL_PTR) begin
                            n_status = STATUS_FULL;
                            n_grant  = '0;
                            n_state  = ST_DONE;
                        end else begin
                            // Grant the lowest free slot, then look above it
                            wr_en    = 1'b1;
                            wr_addr  = r_first_free[AW-1:0];
                            wr_data  = 1'b1;
                            n_status = STATUS_OK;
                            n_grant  = 6'(r_first_free);
                            n_used   = r_used + 1'b1;
                            if (step_stop) begin
                                n_first_free = FULL_PTR;
                                n_end_mark   = FULL_PTR;
                                n_state      = ST_DONE;
                            end else begin
                                n_ptr   = step_next;
                                n_state = ST_ALLOC_RD;
                            end
                        end
                    end else begin
                        n_grant = '0;
                        if (32'(i_in_data.slot_index) >= TABLE_SIZE) begin
                            n_status = STATUS_EMPTY;
                            n_state  = ST_DONE;
                        end else begin
                            n_slot  = AW'(i_in_data.slot_index);
                            n_state = ST_FREE_RD;
                        end
                    end
                end
            end

            // Upward search for the next free slot
            ST_ALLOC_RD: begin
                rd_addr = r_ptr[AW-1:0];
                n_state = ST_ALLOC_CHK;
            end

            ST_ALLOC_CHK: begin
                if (!rd_data) begin
                    n_first_free = r_ptr;
                    if (r_end_mark < r_ptr) begin
                        n_end_mark = r_ptr;
                    end
                    n_state = ST_DONE;
                end else if (step_stop) begin
                    n_first_free = FULL_PTR;
                    n_end_mark   = FULL_PTR;
                    n_state      = ST_DONE;
                end else begin
                    n_ptr   = step_next;
                    n_state = ST_ALLOC_RD;
                end
            end

            // Check that the slot to release is occupied
            ST_FREE_RD: begin
                rd_addr = r_slot;
                n_state = ST_FREE_CHK;
            end

            ST_FREE_CHK: begin
                if (!rd_data) begin
                    n_status = STATUS_EMPTY;
                    n_state  = ST_DONE;
                end else begin
                    wr_en    = 1'b1;
                    wr_addr  = r_slot;
                    wr_data  = 1'b0;
                    n_status = STATUS_OK;
                    if (r_first_free > PW'(r_slot)) begin
                        n_first_free = PW'(r_slot);
                    end
                    if (r_used != '0) begin
                        n_used = r_used - 1'b1;
                    end
                    n_ptr = r_end_mark;
                    if (r_end_mark == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_FREE_SCAN_RD;
                    end
                end
            end

            // Walk the end mark down past trailing empty slots
            ST_FREE_SCAN_RD: begin
                rd_addr = step_next[AW-1:0];
                n_state = ST_FREE_SCAN_CHK;
            end

            ST_FREE_SCAN_CHK: begin
                if (rd_data) begin
                    n_end_mark = r_ptr;
                    n_state    = ST_DONE;
                end else if (step_stop) begin
                    n_end_mark = '0;
                    n_state    = ST_DONE;
                end else begin
                    n_ptr   = step_next;
                    n_state = ST_FREE_SCAN_RD;
                end
            end

            // Hand the result over once the result register is free
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.status       = r_status;
                    n_out.granted_id   = r_grant;
                    n_out.in_use_count = 7'(r_used);
                    n_out.high_mark    = 7'(r_end_mark);
                    n_out_valid        = 1'b1;
                    n_state            = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_first_free <= '0;
            r_end_mark   <= '0;
            r_used       <= '0;
            r_clr_addr   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_first_free <= n_first_free;
            r_end_mark   <= n_end_mark;
            r_used       <= n_used;
            r_clr_addr   <= n_clr_addr;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_slot   <= n_slot;
        r_status <= n_status;
        r_grant  <= n_grant;
        r_out    <= n_out;
    end

    // Occupied count never passes the table size
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= FULL_PTR)
        else $error("used count beyond table size");

    // The lowest free slot never lies above the end mark
    a_free_below_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_first_free <= r_end_mark)
        else $error("free pointer above end mark");

    // An accepted transaction always leaves the idle state
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state != ST_IDLE))
        else $error("sequencer idle after acceptance");

    // A result appears only from the final sequencer state
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid)) |-> $past(r_state == ST_DONE))
        else $error("result raised outside the final state");

endmodule

/* hdl/lfid_map_ram.sv */
// Occupancy map memory: one write port, one read port with registered read data.
module lfid_map_ram #(
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic          i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output logic          o_rd_data
);

    logic r_mem [DEPTH];
    logic r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port (old data on a same-address write)
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/lfid_scan_unit.sv */
// Shared pointer step unit: one increment or decrement with its end-of-range test.
module lfid_scan_unit #(
    parameter int TABLE_SIZE = 64,
    localparam int PW = $clog2(TABLE_SIZE + 1)
) (
    input  lfid_pkg::t_scan_op i_op,
    input  logic [PW-1:0]      i_ptr,
    output logic [PW-1:0]      o_next,
    output logic               o_stop
);

    import lfid_pkg::*;

    localparam logic [PW-1:0] LAST_PTR = PW'(TABLE_SIZE);

    // Step one slot and flag when the walk has run off its end
    always_comb begin
        case (i_op)
            SCAN_UP: begin
                o_next = i_ptr + 1'b1;
                o_stop = (o_next == LAST_PTR);
            end
            SCAN_DOWN: begin
                o_next = i_ptr - 1'b1;
                o_stop = (o_next == '0);
            end
            default: begin
                o_next = i_ptr;
                o_stop = 1'b1;
            end
        endcase
    end

endmodule
